// ===== hdl/crdt_pkg.sv =====
// Shared types and constants for the control/reply de-duplication table.
// Used by every module of the block; depends on nothing else.
package crdt_pkg;

    localparam int NODE_W  = 16;
    localparam int TYPE_W  = 8;
    localparam int NONCE_W = 32;
    localparam int ROUTE_W = 2;

    // Route codes carried on the result channel.
    localparam logic [ROUTE_W-1:0] ROUTE_DROP  = 2'd0;
    localparam logic [ROUTE_W-1:0] ROUTE_LINK  = 2'd1;
    localparam logic [ROUTE_W-1:0] ROUTE_LOCAL = 2'd2;

    // Lookup key of one pending command.
    typedef struct packed {
        logic [NODE_W-1:0]  origin_node;
        logic [NODE_W-1:0]  target_node;
        logic [TYPE_W-1:0]  command_type;
        logic [NONCE_W-1:0] nonce;
    } t_key;

    // One row of the table: occupancy flag and key.
    typedef struct packed {
        logic valid;
        t_key key;
    } t_entry;

    // Compare result for one row against the key under search.
    typedef struct packed {
        logic hit;
        logic free;
    } t_match;

    // One result item.
    typedef struct packed {
        logic [ROUTE_W-1:0] route;
        logic               make_reply;
        logic               table_full;
    } t_result;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_LAST,
        ST_UPDATE
    } t_state;

endpackage

// ===== hdl/crdt_table.sv =====
// Key table storage: one write port and one read port with registered read data.
// Depends on crdt_pkg for the row type.
module crdt_table
    import crdt_pkg::*;
#(
    parameter int ENTRIES = 16,
    localparam int IW = $clog2(ENTRIES)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [IW-1:0] i_waddr,
    input  t_entry        i_wdata,
    input  logic [IW-1:0] i_raddr,
    output t_entry        o_rdata
);

    t_entry r_mem [ENTRIES];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/crdt_match.sv =====
// Shared row comparator: checks one stored row against the search key.
// Depends on crdt_pkg for the row, key and match types.
module crdt_match
    import crdt_pkg::*;
(
    input  t_entry i_row,
    input  t_key   i_key,
    output t_match o_match
);

    always_comb begin
        o_match.hit  = i_row.valid && (i_row.key == i_key);
        o_match.free = !i_row.valid;
    end

endmodule

// ===== hdl/crdt_ctrl.sv =====
// Sequencer of the de-duplication table: clearing pass, row scan, update and result.
// Depends on crdt_pkg and instantiates crdt_match.
module crdt_ctrl
    import crdt_pkg::*;
#(
    parameter int ENTRIES = 16,
    localparam int IW = $clog2(ENTRIES)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_is_reply,
    input  t_key              i_key,
    input  logic [NODE_W-1:0] i_node_id,
    output logic              o_busy,
    input  logic              i_res_ready,
    output logic              o_res_valid,
    output t_result           o_result,
    output logic              o_we,
    output logic [IW-1:0]     o_waddr,
    output t_entry            o_wdata,
    output logic [IW-1:0]     o_raddr,
    input  t_entry            i_rdata
);

    t_state        r_state,    n_state;
    logic [IW-1:0] r_idx,      n_idx;
    logic          r_cmp_en,   n_cmp_en;
    logic [IW-1:0] r_cmp_idx,  n_cmp_idx;
    logic          r_hit,      n_hit;
    logic [IW-1:0] r_hit_idx,  n_hit_idx;
    logic          r_free,     n_free;
    logic [IW-1:0] r_free_idx, n_free_idx;
    t_key          r_key,      n_key;
    logic          r_is_reply, n_is_reply;

    t_match        match;
    logic          idx_last;
    logic          tgt_here;
    logic          org_here;
    t_result       res;
    logic          upd_we;
    logic [IW-1:0] upd_addr;
    t_entry        upd_data;

    crdt_match u_match (
        .i_row   (i_rdata),
        .i_key   (r_key),
        .o_match (match)
    );

    assign idx_last = (r_idx == IW'(ENTRIES - 1));
    assign tgt_here = (r_key.target_node == i_node_id);
    assign org_here = (r_key.origin_node == i_node_id);
    assign o_busy   = (r_state != ST_IDLE);

    // Decision from the finished scan.
    always_comb begin
        res            = '0;
        res.route      = ROUTE_DROP;
        upd_we         = 1'b0;
        upd_addr       = r_free_idx;
        upd_data.valid = 1'b1;
        upd_data.key   = r_key;
        if (!r_is_reply) begin
            if (!r_hit) begin
                res.route = tgt_here ? ROUTE_LOCAL : ROUTE_LINK;
                if (r_free) begin
                    upd_we = 1'b1;
                end else begin
                    res.table_full = 1'b1;
                end
            end else if (tgt_here) begin
                res.route      = ROUTE_LINK;
                res.make_reply = 1'b1;
            end
        end else if (r_hit) begin
            upd_we         = 1'b1;
            upd_addr       = r_hit_idx;
            upd_data.valid = 1'b0;
            res.route      = org_here ? ROUTE_DROP : ROUTE_LINK;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_cmp_en   = r_cmp_en;
        n_cmp_idx  = r_cmp_idx;
        n_hit      = r_hit;
        n_hit_idx  = r_hit_idx;
        n_free     = r_free;
        n_free_idx = r_free_idx;
        n_key      = r_key;
        n_is_reply = r_is_reply;
        o_we        = 1'b0;
        o_waddr     = r_idx;
        o_wdata     = '0;
        o_raddr     = r_idx;
        o_res_valid = 1'b0;
        o_result    = res;

        // Fold in the row read in the previous cycle; lowest index wins.
        if (r_cmp_en) begin
            if (match.hit && !r_hit) begin
                n_hit     = 1'b1;
                n_hit_idx = r_cmp_idx;
            end
            if (match.free && !r_free) begin
                n_free     = 1'b1;
                n_free_idx = r_cmp_idx;
            end
        end

        unique case (r_state)
            ST_CLEAR: begin
                o_we    = 1'b1;
                o_waddr = r_idx;
                if (idx_last) begin
                    n_idx   = '0;
                    n_state = ST_IDLE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            ST_IDLE: begin
                n_cmp_en = 1'b0;
                if (i_start) begin
                    n_key      = i_key;
                    n_is_reply = i_is_reply;
                    n_hit      = 1'b0;
                    n_free     = 1'b0;
                    n_idx      = '0;
                    n_state    = ST_SCAN;
                end
            end
            ST_SCAN: begin
                o_raddr   = r_idx;
                n_cmp_en  = 1'b1;
                n_cmp_idx = r_idx;
                if (idx_last) begin
                    n_state = ST_LAST;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            ST_LAST: begin
                n_cmp_en = 1'b0;
                n_state  = ST_UPDATE;
            end
            ST_UPDATE: begin
                if (i_res_ready) begin
                    o_res_valid = 1'b1;
                    o_we        = upd_we;
                    o_waddr     = upd_addr;
                    o_wdata     = upd_data;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLEAR;
            r_idx    <= '0;
            r_cmp_en <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_idx    <= n_idx;
            r_cmp_en <= n_cmp_en;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmp_idx  <= n_cmp_idx;
        r_hit      <= n_hit;
        r_hit_idx  <= n_hit_idx;
        r_free     <= n_free;
        r_free_idx <= n_free_idx;
        r_key      <= n_key;
        r_is_reply <= n_is_reply;
    end

    a_we_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_we |-> (r_state == ST_CLEAR || r_state == ST_UPDATE))
        else $error("table write outside clearing pass or update");

    a_res_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |=> (r_state == ST_IDLE))
        else $error("sequencer did not return to idle after a result");

    a_reply_link: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_result.make_reply) |-> (o_result.route == ROUTE_LINK))
        else $error("reply rewrite without link route");

    a_full_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_result.table_full) |-> !o_we)
        else $error("entry written although table reported full");

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> (r_state == ST_IDLE))
        else $error("item started while sequencer busy");

endmodule

// ===== hdl/control_reply_dedup_table_core.sv =====
// Top level of the control/reply de-duplication table.
// Depends on crdt_pkg, crdt_table, crdt_match (through crdt_ctrl) and crdt_ctrl.

// The block takes one message header per input transfer and returns exactly one
// routing result per header. Pending control commands are kept in a table of
// TABLE_ENTRIES rows, keyed by origin node, target node, command type and nonce.
// A new control message is recorded in the lowest free row and routed locally
// (route 2) when its target equals node_id, else to the link (route 1); if no
// row is free it is still routed that way and table_full is set. A repeated
// control message aimed at this node returns route 1 with make_reply set, so the
// packet is rewritten as a reply; other repeats are dropped. A reply
// whose key is stored frees that row and is dropped when this node issued the
// command, else sent to the link; a reply with an unknown key is dropped.
// The single table read port and the one shared row comparator visit every row
// once, one row per cycle, in ST_SCAN; ST_LAST then compares the last row read,
// and ST_UPDATE applies the update and registers the result once the output
// register can take it. The input is stalled from the input transfer until the
// result is registered, so a new header is not taken while one is in flight.
// A finished result sits in an output register, so the next header is taken
// while it waits; only the update of that next header waits for the output to
// drain.
// After reset the table is cleared by a pass over every row, during
// which the input is stalled. node_id is written through the configuration
// channel, which is always ready and must only be used while the block is idle.
module control_reply_dedup_table_core
    import crdt_pkg::*;
#(
    parameter int TABLE_ENTRIES = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration write channel
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [NODE_W-1:0]  i_cfg_data,
    // input channel
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_is_reply,
    input  logic [NODE_W-1:0]  i_origin_node,
    input  logic [NODE_W-1:0]  i_target_node,
    input  logic [TYPE_W-1:0]  i_command_type,
    input  logic [NONCE_W-1:0] i_nonce,
    // result channel
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [ROUTE_W-1:0] o_route,
    output logic               o_make_reply,
    output logic               o_table_full
);

    localparam int IW = $clog2(TABLE_ENTRIES);

    logic [NODE_W-1:0] r_node_id, n_node_id;
    logic              r_out_valid, n_out_valid;
    t_result           r_out, n_out;

    logic              busy;
    logic              start;
    t_key              key;
    logic              res_ready;
    logic              res_valid;
    t_result           result;
    logic              mem_we;
    logic [IW-1:0]     mem_waddr;
    t_entry            mem_wdata;
    logic [IW-1:0]     mem_raddr;
    t_entry            mem_rdata;

    // The node identifier register accepts a write in any cycle.
    assign o_cfg_ready = 1'b1;
    assign n_node_id   = (i_cfg_valid && o_cfg_ready) ? i_cfg_data : r_node_id;

    assign o_in_stall = busy;
    assign start      = i_in_valid && !busy;

    always_comb begin
        key.origin_node  = i_origin_node;
        key.target_node  = i_target_node;
        key.command_type = i_command_type;
        key.nonce        = i_nonce;
    end

    // The output register can take a new result when empty or being drained.
    assign res_ready = !r_out_valid || !i_out_stall;

    always_comb begin
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (res_valid) begin
            n_out_valid = 1'b1;
            n_out       = result;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    crdt_ctrl #(
        .ENTRIES (TABLE_ENTRIES)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_is_reply  (i_is_reply),
        .i_key       (key),
        .i_node_id   (r_node_id),
        .o_busy      (busy),
        .i_res_ready (res_ready),
        .o_res_valid (res_valid),
        .o_result    (result),
        .o_we        (mem_we),
        .o_waddr     (mem_waddr),
        .o_wdata     (mem_wdata),
        .o_raddr     (mem_raddr),
        .i_rdata     (mem_rdata)
    );

    crdt_table #(
        .ENTRIES (TABLE_ENTRIES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_id   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_node_id   <= n_node_id;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_out_valid  = r_out_valid;
    assign o_route      = r_out.route;
    assign o_make_reply = r_out.make_reply;
    assign o_table_full = r_out.table_full;

endmodule

// ===== tb/tb_control_reply_dedup_table_core.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for control_reply_dedup_table_core: directed and random headers.
// Depends on crdt_pkg and the block's RTL; a scoreboard class predicts every route.
module tb_control_reply_dedup_table_core;
    import crdt_pkg::*;

    localparam int TABLE_ENTRIES = 16;
    localparam int CLK_HALF      = 6;
    // Cycles to let pass after the clearing pass or a drain before touching node_id.
    localparam int SETTLE_CYCLES = TABLE_ENTRIES + 8;
    localparam int PHASES        = 9;
    localparam int PHASE_ITEMS   = 148;
    localparam int SPENT_MAX     = 32;

    // Idling patterns, one per random phase.
    localparam int MODE_BOTH = 0;
    localparam int MODE_NONE = 1;
    localparam int MODE_SEND = 2;
    localparam int MODE_RECV = 3;

    // Holds a mirror of the pending-command table and the routes still owed by the block.
    class route_scoreboard;
        logic [NODE_W-1:0] node_id;
        bit                held[TABLE_ENTRIES];
        t_key              keys[TABLE_ENTRIES];
        t_result           pending_routes[$];
        int                errors;

        function new();
            node_id = '0;
            errors  = 0;
            foreach (held[i]) held[i] = 1'b0;
        endfunction

        // Works out the route for one accepted header and updates the mirror table.
        function void predict_route(bit is_reply, t_key key);
            int      hit;
            int      slot;
            t_result want;
            hit  = -1;
            slot = -1;
            want.route      = ROUTE_DROP;
            want.make_reply = 1'b0;
            want.table_full = 1'b0;
            foreach (held[i]) begin
                if (hit < 0 && held[i] && keys[i] == key) hit = i;
                if (slot < 0 && !held[i]) slot = i;
            end
            if (!is_reply) begin
                if (hit < 0) begin
                    // New command: store it in the lowest free row, if any.
                    if (slot >= 0) begin
                        held[slot] = 1'b1;
                        keys[slot] = key;
                    end else begin
                        want.table_full = 1'b1;
                    end
                    want.route = (key.target_node == node_id) ? ROUTE_LOCAL : ROUTE_LINK;
                end else if (key.target_node == node_id) begin
                    // Repeat aimed at this node is bounced back as a reply.
                    want.route      = ROUTE_LINK;
                    want.make_reply = 1'b1;
                end
            end else if (hit >= 0) begin
                held[hit]  = 1'b0;
                want.route = (key.origin_node == node_id) ? ROUTE_DROP : ROUTE_LINK;
            end
            pending_routes.push_back(want);
        endfunction

        // Compares one accepted result with the oldest outstanding route.
        function void compare_route(t_result got);
            t_result want;
            if (pending_routes.size() == 0) begin
                $error("unexpected result: route %0d make_reply %0d table_full %0d",
                       got.route, got.make_reply, got.table_full);
                errors++;
                return;
            end
            want = pending_routes.pop_front();
            if (got.route !== want.route) begin
                $error("route: expected %0d, actual %0d", want.route, got.route);
                errors++;
            end
            if (got.make_reply !== want.make_reply) begin
                $error("make_reply: expected %0d, actual %0d", want.make_reply, got.make_reply);
                errors++;
            end
            if (got.table_full !== want.table_full) begin
                $error("table_full: expected %0d, actual %0d", want.table_full, got.table_full);
                errors++;
            end
        endfunction

        // Picks the key of a random occupied row; returns 0 when the table is empty.
        function bit pick_held(output t_key key);
            int rows[$];
            foreach (held[i]) if (held[i]) rows.push_back(i);
            if (rows.size() == 0) return 1'b0;
            key = keys[rows[$urandom_range(0, rows.size() - 1)]];
            return 1'b1;
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [NODE_W-1:0]  i_cfg_data;
    logic               i_in_valid;
    logic               o_in_stall;
    logic               i_is_reply;
    logic [NODE_W-1:0]  i_origin_node;
    logic [NODE_W-1:0]  i_target_node;
    logic [TYPE_W-1:0]  i_command_type;
    logic [NONCE_W-1:0] i_nonce;
    logic               o_out_valid;
    logic               i_out_stall;
    logic [ROUTE_W-1:0] o_route;
    logic               o_make_reply;
    logic               o_table_full;

    route_scoreboard routes = new();

    // Whether each side inserts random idle cycles, and the gap drawn for the next header.
    bit   send_idles;
    bit   recv_idles;
    int   gap_ahead;
    // Keys whose reply has already been sent, for replies that should miss.
    t_key spent_keys[$];

    control_reply_dedup_table_core #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_is_reply     (i_is_reply),
        .i_origin_node  (i_origin_node),
        .i_target_node  (i_target_node),
        .i_command_type (i_command_type),
        .i_nonce        (i_nonce),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_route        (o_route),
        .o_make_reply   (o_make_reply),
        .o_table_full   (o_table_full)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Generous limit: roughly ten times the slowest legal run.
    initial begin : watchdog
        #(10_000_000);
        $display("end of test: mismatches");
        $finish;
    end

    function automatic t_key mk_key(logic [NODE_W-1:0] origin, logic [NODE_W-1:0] target,
                                    logic [TYPE_W-1:0] ctype, logic [NONCE_W-1:0] nonce);
        t_key key;
        key.origin_node  = origin;
        key.target_node  = target;
        key.command_type = ctype;
        key.nonce        = nonce;
        return key;
    endfunction

    // A new key whose nodes often equal node_id, so that every route is reached.
    function automatic t_key fresh_key();
        t_key key;
        key.origin_node  = ($urandom_range(0, 3) == 0) ? routes.node_id : NODE_W'($urandom);
        key.target_node  = ($urandom_range(0, 2) == 0) ? routes.node_id : NODE_W'($urandom);
        key.command_type = TYPE_W'($urandom);
        key.nonce        = $urandom;
        return key;
    endfunction

    // Sends one header. Entered and left just after a falling edge; the gap before the
    // next header is drawn at the end so valid is only lowered when a gap follows.
    task automatic send_header(input bit is_reply, input t_key key);
        repeat (gap_ahead) @(negedge i_clk);
        i_in_valid     = 1'b1;
        i_is_reply     = is_reply;
        i_origin_node  = key.origin_node;
        i_target_node  = key.target_node;
        i_command_type = key.command_type;
        i_nonce        = key.nonce;
        do @(posedge i_clk); while (o_in_stall);
        routes.predict_route(is_reply, key);
        @(negedge i_clk);
        gap_ahead = send_idles ? $urandom_range(0, 15) : 0;
        if (gap_ahead > 0) i_in_valid = 1'b0;
    endtask

    // Holds the sender off until every expected route has been returned.
    task automatic wait_drain();
        i_in_valid = 1'b0;
        gap_ahead  = 0;
        while (routes.pending_routes.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // node_id may only change while the block is idle, so drain and let it settle first.
    task automatic write_node_id(input logic [NODE_W-1:0] value);
        wait_drain();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_data  = value;
        do @(posedge i_clk); while (!o_cfg_ready);
        routes.node_id = value;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // One random header: new keys, or keys reused from the table so that repeats, known
    // replies and a full table all occur; the rest is unknown replies and noise.
    task automatic send_random_item(input int w_new, input int w_reply);
        int   roll;
        t_key key;
        roll = $urandom_range(0, 99);
        if (roll < w_new) begin
            send_header(1'b0, fresh_key());
        end else if (roll < w_new + 15) begin
            if (!routes.pick_held(key)) key = fresh_key();
            send_header(1'b0, key);
        end else if (roll < w_new + 15 + w_reply) begin
            if (routes.pick_held(key)) begin
                spent_keys.push_back(key);
                if (spent_keys.size() > SPENT_MAX) void'(spent_keys.pop_front());
            end else begin
                key = fresh_key();
            end
            send_header(1'b1, key);
        end else if (roll < w_new + 25 + w_reply && spent_keys.size() != 0) begin
            send_header(1'b1, spent_keys[$urandom_range(0, spent_keys.size() - 1)]);
        end else begin
            key = mk_key(NODE_W'($urandom), NODE_W'($urandom), TYPE_W'($urandom), $urandom);
            send_header(1'($urandom), key);
        end
    endtask

    // Result side: if recv_idles, stalls at random before each transfer; then checks it.
    initial begin : result_sink
        int      stall_cycles;
        t_result got;
        @(posedge i_rst_n);
        forever begin
            stall_cycles = recv_idles ? $urandom_range(0, 15) : 0;
            @(negedge i_clk);
            if (stall_cycles > 0) begin
                i_out_stall = 1'b1;
                repeat (stall_cycles) @(negedge i_clk);
            end
            i_out_stall = 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
            got.route      = o_route;
            got.make_reply = o_make_reply;
            got.table_full = o_table_full;
            routes.compare_route(got);
        end
    end

    initial begin : stimulus
        int   ph;
        int   n;
        int   mode;
        t_key far_key;
        t_key spill_key;
        t_key here_key;

        i_rst_n        = 1'b0;
        i_cfg_valid    = 1'b0;
        i_cfg_data     = '0;
        i_in_valid     = 1'b0;
        i_is_reply     = 1'b0;
        i_origin_node  = '0;
        i_target_node  = '0;
        i_command_type = '0;
        i_nonce        = '0;
        i_out_stall    = 1'b0;
        send_idles     = 1'b1;
        recv_idles     = 1'b1;
        gap_ahead      = 0;

        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;
        // The block clears its table after reset with the input stalled.
        repeat (SETTLE_CYCLES) @(negedge i_clk);

        // Directed part, first with node_id at its reset value of zero.
        send_header(1'b0, mk_key('0, '0, '0, '0));  // new command for this node
        send_header(1'b0, mk_key('0, '0, '0, '0));  // repeat here, rewritten as reply
        send_header(1'b1, mk_key('0, '0, '0, '0));  // known reply issued here, dropped
        send_header(1'b1, mk_key('0, '0, '0, '0));  // same reply again is unknown
        far_key = mk_key('1, '1, '1, '1);
        send_header(1'b0, far_key);                 // new command for another node
        send_header(1'b0, far_key);                 // repeat elsewhere, dropped
        send_header(1'b1, far_key);                 // known reply from elsewhere, to link

        write_node_id(16'hFFFF);
        here_key = mk_key(16'h0000, 16'hFFFF, 8'h5A, 32'h8000_0001);
        send_header(1'b0, here_key);
        // Fill every remaining row, then overflow the table.
        for (n = 1; n < TABLE_ENTRIES; n++)
            send_header(1'b0, mk_key(16'h0001, 16'h0002, TYPE_W'(n), 32'hA5A5_0000 ^ n));
        send_header(1'b0, mk_key(16'h0003, 16'hFFFF, 8'h00, 32'h0));  // full, still local
        spill_key = mk_key(16'h0003, 16'h0004, 8'h00, 32'h0);
        send_header(1'b0, spill_key);                // full, still to link
        send_header(1'b1, here_key);                 // frees the lowest row
        send_header(1'b0, spill_key);                // now it fits

        // Random phases, each with its own node_id and idling pattern.
        for (ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0:       write_node_id(16'h0000);
                1:       write_node_id(16'hFFFF);
                2:       write_node_id(16'h0001);
                3:       write_node_id(16'h8000);
                4:       write_node_id(16'hFFFE);
                5:       write_node_id(16'h7FFF);
                default: write_node_id(NODE_W'($urandom));
            endcase
            mode = ph % 4;
            send_idles = (mode == MODE_BOTH) || (mode == MODE_SEND);
            recv_idles = (mode == MODE_BOTH) || (mode == MODE_RECV);
            for (n = 0; n < PHASE_ITEMS; n++) begin
                // Halfway through, let the block run completely dry once.
                if (n == PHASE_ITEMS / 2) wait_drain();
                // Even phases lean toward filling the table, odd ones toward emptying it.
                if (ph % 2 == 0) send_random_item(35, 20);
                else send_random_item(15, 40);
            end
        end

        wait_drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (routes.errors == 0 && routes.pending_routes.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
